// File: rtl/crca_pkg.sv
// crca_pkg: shared types, widths and helpers for cross region cost aggregation
// no dependencies
package crca_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_MAX_ARM    = 15;

    localparam int POS_W  = 9;
    localparam int SIZE_W = 10;
    localparam int COST_W = 16;
    localparam int ARM_W  = 4;
    localparam int CNT_W  = 10;
    localparam int OUT_W  = 25;
    localparam int CRD_W  = 14;
    localparam int OFF_W  = 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic signed [63:0] OUT_MAX_L = 64'sd16777215;
    localparam logic signed [63:0] OUT_MIN_L = -64'sd16777216;

    typedef struct packed {
        logic signed [COST_W-1:0] cost;
        logic                     valid;
        logic [ARM_W-1:0]         arm_down;
        logic [ARM_W-1:0]         arm_up;
        logic [ARM_W-1:0]         arm_right;
        logic [ARM_W-1:0]         arm_left;
        logic [CNT_W-1:0]         count;
    } t_pix;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CTR,
        S_ROW_ISSUE,
        S_ROW,
        S_PIX,
        S_DRAIN,
        S_DIV,
        S_OUT
    } t_state;

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > OUT_MAX_L) r = OUT_MAX_L;
        if (v < OUT_MIN_L) r = OUT_MIN_L;
        return r[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/crca_ram.sv
// crca_ram: generic single write, single read ram with registered read data
// no dependencies
module crca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/crca_div.sv
// crca_div: restoring divider, one quotient bit per cycle
// depends on crca_pkg
module crca_div #(
    parameter int DIVD_W = 26
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DIVD_W-1:0]          i_dividend,
    input  logic [crca_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [DIVD_W-1:0]          o_quotient
);
    import crca_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_d, n_d;
    logic [DIVD_W-1:0] r_q, n_q;
    logic [CNT_W:0]    rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_d    = r_d;
        n_q    = r_q;
        rem_sh = {r_rem, r_q[DIVD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(DIVD_W);
            n_rem  = '0;
            n_d    = i_divisor;
            n_q    = i_dividend;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_d}) begin
                n_rem = CNT_W'(rem_sh - {1'b0, r_d});
                n_q   = {r_q[DIVD_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[CNT_W-1:0];
                n_q   = {r_q[DIVD_W-2:0], 1'b0};
            end
            n_step = r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_d    <= n_d;
        r_q    <= n_q;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// File: rtl/cross_region_cost_aggregation.sv
// cross_region_cost_aggregation: per pixel store and cross region cost query
// depends on crca_pkg, crca_ram, crca_div
//
//  channel | dir | handshake                | payload
//  in      | in  | i_in_valid / o_in_stall  | i_op, i_pos_x .. i_support_count
//  out     | out | o_out_valid / i_out_stall| o_aggregated_cost
//  cfg     | in  | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// a load beat writes the pixel store when its position lies inside the frame
// a query reads the centre pixel, then per row of the vertical arm skips a row outside
// the frame or a masked row, else reads its pixels from left arm to right arm; the sum
// is divided by a nonzero count; the single store read port reads one pixel at a time
// reset clears control and sets frame size to 512 x 512; store contents are kept
// a result waits in the output register while loads continue to be taken
module cross_region_cost_aggregation #(
    parameter int MAX_WIDTH  = crca_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crca_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_ARM    = crca_pkg::DEF_MAX_ARM
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [crca_pkg::SIZE_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_op,
    input  logic [crca_pkg::POS_W-1:0]         i_pos_x,
    input  logic [crca_pkg::POS_W-1:0]         i_pos_y,
    input  logic signed [crca_pkg::COST_W-1:0] i_cost_in,
    input  logic                               i_pixel_valid,
    input  logic [crca_pkg::ARM_W-1:0]         i_arm_left,
    input  logic [crca_pkg::ARM_W-1:0]         i_arm_right,
    input  logic [crca_pkg::ARM_W-1:0]         i_arm_up,
    input  logic [crca_pkg::ARM_W-1:0]         i_arm_down,
    input  logic [crca_pkg::CNT_W-1:0]         i_support_count,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [crca_pkg::OUT_W-1:0]  o_aggregated_cost
);
    import crca_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = $clog2((2 * MAX_ARM + 1) * (2 * MAX_ARM + 1)) + COST_W;

    function automatic logic [ARM_W-1:0] clamp_arm(input logic [ARM_W-1:0] a);
        return (int'(a) > MAX_ARM) ? ARM_W'(MAX_ARM) : a;
    endfunction

    function automatic logic [ADDR_W-1:0] pix_addr(input logic signed [CRD_W-1:0] x,
                                                  input logic signed [CRD_W-1:0] y);
        return ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
    endfunction

    t_state r_state, n_state;

    logic [SIZE_W-1:0]        r_cfg_w, r_cfg_h;
    logic signed [CRD_W-1:0]  w_act, h_act;
    logic signed [CRD_W-1:0]  r_px, n_px, r_py, n_py, r_ry, n_ry;
    logic signed [OFF_W-1:0]  r_dy, n_dy, r_down, n_down, r_dx, n_dx, r_hi, n_hi;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_inside, n_inside;
    logic                     r_pend, n_pend;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [OUT_W-1:0]         r_res, n_res;
    logic                     r_out_valid, n_out_valid;
    logic [OUT_W-1:0]         r_out, n_out;

    logic                     in_acc, in_inside, out_free, row_end, y_ok, x_ok;
    logic signed [CRD_W-1:0]  in_x, in_y, y_s, x_s;
    logic [ADDR_W-1:0]        raddr, waddr;
    t_pix                     wdata, rdata;
    logic                     ram_we, div_start, div_done;
    logic [ACC_W-1:0]         div_q, div_mag;
    logic signed [ACC_W-1:0]  div_sgn;

    assign w_act = (r_cfg_w == '0) ? CRD_W'(1) :
                   (int'(r_cfg_w) > MAX_WIDTH) ? CRD_W'(MAX_WIDTH) : CRD_W'(r_cfg_w);
    assign h_act = (r_cfg_h == '0) ? CRD_W'(1) :
                   (int'(r_cfg_h) > MAX_HEIGHT) ? CRD_W'(MAX_HEIGHT) : CRD_W'(r_cfg_h);

    assign in_acc    = i_in_valid && !o_in_stall;
    assign in_x      = CRD_W'(i_pos_x);
    assign in_y      = CRD_W'(i_pos_y);
    assign in_inside = (in_x < w_act) && (in_y < h_act);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign y_s     = r_py + CRD_W'(r_dy);
    assign y_ok    = (y_s >= 0) && (y_s < h_act);
    assign row_end = r_dy > r_down;
    assign x_s     = r_px + CRD_W'(r_dx);
    assign x_ok    = (x_s >= 0) && (x_s < w_act);

    assign ram_we = in_acc && (i_op == OP_LOAD) && in_inside;
    assign waddr  = pix_addr(in_x, in_y);
    assign wdata  = '{cost: i_cost_in, valid: i_pixel_valid, arm_down: i_arm_down,
                      arm_up: i_arm_up, arm_right: i_arm_right, arm_left: i_arm_left,
                      count: i_support_count};

    always_comb begin
        case (r_state)
            S_ROW_ISSUE: raddr = pix_addr(r_px, y_s);
            S_PIX:       raddr = pix_addr(x_s, r_ry);
            default:     raddr = waddr;
        endcase
    end

    crca_ram #(.WIDTH($bits(t_pix)), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign div_mag   = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign div_start = (r_state == S_ROW_ISSUE) && row_end && (r_cnt != '0);
    assign div_sgn   = r_acc[ACC_W-1] ? -$signed(div_q) : $signed(div_q);

    crca_div #(.DIVD_W(ACC_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_mag),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_op == OP_QUERY) n_state = in_inside ? S_CTR : S_OUT;
            end
            S_CTR: begin
                n_state = (r_inside && rdata.valid) ? S_ROW_ISSUE : S_OUT;
            end
            S_ROW_ISSUE: begin
                if (row_end) n_state = (r_cnt == '0) ? S_OUT : S_DIV;
                else if (y_ok) n_state = S_ROW;
            end
            S_ROW: begin
                n_state = rdata.valid ? S_PIX : S_ROW_ISSUE;
            end
            S_PIX: begin
                if (r_dx == r_hi) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_ROW_ISSUE;
            S_DIV: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_px        = r_px;
        n_py        = r_py;
        n_ry        = r_ry;
        n_dy        = r_dy;
        n_down      = r_down;
        n_dx        = r_dx;
        n_hi        = r_hi;
        n_cnt       = r_cnt;
        n_inside    = r_inside;
        n_pend      = 1'b0;
        n_acc       = r_acc;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (r_pend && rdata.valid) n_acc = r_acc + ACC_W'(rdata.cost);
        case (r_state)
            S_IDLE: begin
                n_px     = in_x;
                n_py     = in_y;
                n_inside = in_inside;
                n_res    = '0;
            end
            S_CTR: begin
                n_dy   = -$signed(OFF_W'(clamp_arm(rdata.arm_up)));
                n_down = $signed(OFF_W'(clamp_arm(rdata.arm_down)));
                n_cnt  = rdata.count;
                n_acc  = '0;
            end
            S_ROW_ISSUE: begin
                n_ry = y_s;
                if (row_end) n_res = sat_out(64'(r_acc));
                else if (!y_ok) n_dy = r_dy + OFF_W'(1);
            end
            S_ROW: begin
                n_dx = -$signed(OFF_W'(clamp_arm(rdata.arm_left)));
                n_hi = $signed(OFF_W'(clamp_arm(rdata.arm_right)));
                if (!rdata.valid) n_dy = r_dy + OFF_W'(1);
            end
            S_PIX: begin
                n_pend = x_ok;
                n_dx   = r_dx + OFF_W'(1);
            end
            S_DRAIN: n_dy = r_dy + OFF_W'(1);
            S_DIV: begin
                if (div_done) n_res = sat_out(64'(div_sgn));
            end
            S_OUT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_cfg_w     <= SIZE_W'(512);
            r_cfg_h     <= SIZE_W'(512);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            if (i_cfg_we && i_cfg_idx == CFG_FRAME_WIDTH) r_cfg_w <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_FRAME_HEIGHT) r_cfg_h <= i_cfg_data;
        end
        r_px     <= n_px;
        r_py     <= n_py;
        r_ry     <= n_ry;
        r_dy     <= n_dy;
        r_down   <= n_down;
        r_dx     <= n_dx;
        r_hi     <= n_hi;
        r_cnt    <= n_cnt;
        r_inside <= n_inside;
        r_acc    <= n_acc;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_stall        = r_state != S_IDLE;
    assign o_out_valid       = r_out_valid;
    assign o_aggregated_cost = r_out;
endmodule

// File: rtl/crca_chk.sv
// crca_chk: port level assertions for cross_region_cost_aggregation, bound in
// depends on crca_pkg
module crca_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_op,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [crca_pkg::OUT_W-1:0] o_aggregated_cost
);
    import crca_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_aggregated_cost))
        else $error("result beat changed under stall");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op == OP_LOAD && !o_out_valid |=> !o_out_valid)
        else $error("load beat produced a result");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op == OP_QUERY |=> o_in_stall)
        else $error("query beat did not start work");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");
endmodule

bind cross_region_cost_aggregation crca_chk u_crca_chk (.*);
